// ----- hw/rtl/light_bar_pixel_mask_defines.svh -----
// assertion helpers used by the light bar mask rtl
`ifndef LIGHT_BAR_PIXEL_MASK_DEFINES_SVH
`define LIGHT_BAR_PIXEL_MASK_DEFINES_SVH

// condition must hold at every rising clock edge out of reset
`define LBPM_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// consequence must hold in the cycle after the antecedent
`define LBPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lbpm_pkg.sv -----
package lbpm_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  // result queue depth, room for two results plus steady-state slack
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // dilation window: columns x-2..x+1 around the delayed pixel
  localparam int WIN_W = 4;

  // gray weights, they sum to 1 << GRAY_SHIFT
  localparam int GRAY_SHIFT = 14;
  localparam int GRAY_ACC_W = 22;
  localparam logic [GRAY_ACC_W-1:0] W_BLUE  = GRAY_ACC_W'(1868);
  localparam logic [GRAY_ACC_W-1:0] W_GREEN = GRAY_ACC_W'(9617);
  localparam logic [GRAY_ACC_W-1:0] W_RED   = GRAY_ACC_W'(4899);
  localparam logic [GRAY_ACC_W-1:0] GRAY_RND = GRAY_ACC_W'(8192);

  typedef enum logic [1:0] {
    REG_ENEMY_IS_BLUE  = 2'd0,
    REG_GRAY_THRESHOLD = 2'd1,
    REG_RED_THRESHOLD  = 2'd2,
    REG_BLUE_THRESHOLD = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       frame_end;
  } pix_t;

  typedef struct packed {
    logic light_mask;
    logic bright_mask;
    logic out_row_end;
    logic out_frame_end;
  } res_t;

  // results handed to the queue in the same cycle, first one leaves first
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } res_push_t;

  function automatic logic [7:0] gray_of(input pix_t p);
    logic [GRAY_ACC_W-1:0] acc;
    acc = W_BLUE * GRAY_ACC_W'(p.blue) + W_GREEN * GRAY_ACC_W'(p.green)
        + W_RED * GRAY_ACC_W'(p.red) + GRAY_RND;
    return acc[GRAY_ACC_W-1:GRAY_SHIFT];
  endfunction

  // saturating channel difference against the selected threshold
  function automatic logic color_hit(input pix_t p, input logic blue_rule,
                                     input logic [7:0] red_thr,
                                     input logic [7:0] blue_thr);
    logic [7:0] diff;
    logic [7:0] thr;
    if (blue_rule) begin
      diff = (p.blue > p.red) ? p.blue - p.red : 8'd0;
      thr  = blue_thr;
    end else begin
      diff = (p.red > p.blue) ? p.red - p.blue : 8'd0;
      thr  = red_thr;
    end
    return diff > thr;
  endfunction

endpackage

// ----- hw/rtl/lbpm_res_fifo.sv -----
module lbpm_res_fifo
  import lbpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  res_push_t            push_i,
  output logic [RES_CNT_W-1:0] count_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output res_t                 out_res_o
);

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic                 pop;
  logic [RES_PTR_W-1:0] wr_ptr_nx;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign count_o     = count_q;
  assign wr_ptr_nx   = wr_ptr_q + RES_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_i.num);
    rd_ptr_d = pop ? rd_ptr_q + RES_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + RES_CNT_W'(push_i.num) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

endmodule

// ----- hw/rtl/light_bar_pixel_mask.sv -----
// channel   direction  payload         handshake
// in        input      pix_t in_pix_i  in_valid_i / in_ready_o
// out       output     res_t out_res_o out_valid_o / out_ready_i
// cfg       input      apb registers   psel / penable / pwrite, pready tied high
//
// one pixel item per cycle while the queue has room; results enter the queue when the
// item that releases them advances, a mid-row pixel is released by the pixel after it
// input register -> gray, threshold and window logic -> four-entry result queue
// a row end item yields two results (one in a one-pixel row), a row start item none
// in_ready_o drops only while the queue lacks room for the held item's results
// reset clears control state and the line buffer fill count, no clearing pass
// line buffer: one-bit memory, read one column ahead with a registered read
`include "light_bar_pixel_mask_defines.svh"

module light_bar_pixel_mask
  import lbpm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pix_t        in_pix_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_res_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int FILL_W = $clog2(MAX_WIDTH + 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

  typedef struct packed {
    logic bright;
    logic color;
  } pend_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic       enemy_blue_q;
  logic [7:0] gray_thr_q;
  logic [7:0] red_thr_q;
  logic [7:0] blue_thr_q;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enemy_blue_q <= 1'b0;
      gray_thr_q   <= '0;
      red_thr_q    <= '0;
      blue_thr_q   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENEMY_IS_BLUE:  enemy_blue_q <= pwdata[0];
        REG_GRAY_THRESHOLD: gray_thr_q   <= pwdata[7:0];
        REG_RED_THRESHOLD:  red_thr_q    <= pwdata[7:0];
        REG_BLUE_THRESHOLD: blue_thr_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENEMY_IS_BLUE:  prdata = {31'd0, enemy_blue_q};
      REG_GRAY_THRESHOLD: prdata = {24'd0, gray_thr_q};
      REG_RED_THRESHOLD:  prdata = {24'd0, red_thr_q};
      REG_BLUE_THRESHOLD: prdata = {24'd0, blue_thr_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  logic a_valid_q;
  pix_t a_pix_q;
  logic a_adv;
  logic in_acc;

  assign in_ready_o = !a_valid_q || a_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_pix_q <= in_pix_i;
    end
  end

  // ---------------------------------------------------------------------
  // row state
  // ---------------------------------------------------------------------
  logic [COL_W-1:0]  col_q, col_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WIN_W-2:0]  cur_win_q, cur_win_d;
  logic [WIN_W-2:0]  prev_win_q, prev_win_d;
  pend_t             pend_q, pend_d;
  logic              first_row_q, first_row_d;

  // line buffer read path
  logic lb_mem [MAX_WIDTH];
  logic lb_rd_q;
  logic lb_fwd_q, lb_fwd_bit_q, lb_ok_q;

  logic              bright, color;
  logic              prev_bit;
  logic [WIN_W-1:0]  cwin, pwin, win;
  logic              rend, has_mid;
  logic [1:0]        num;
  logic [COL_W-1:0]  next_col;
  logic [FILL_W-1:0] col_ext;
  logic [RES_CNT_W-1:0] fifo_count;
  logic [RES_CNT_W-1:0] free;
  res_t              res_mid, res_end;
  res_push_t         push;

  assign bright = gray_of(a_pix_q) > gray_thr_q;
  assign color  = color_hit(a_pix_q, enemy_blue_q, red_thr_q, blue_thr_q);

  // previous row bit: none in the first row, nothing past the filled part
  assign prev_bit = !first_row_q && lb_ok_q && (lb_fwd_q ? lb_fwd_bit_q : lb_rd_q);

  assign pwin = {prev_win_q, prev_bit};
  assign cwin = {cur_win_q, bright};
  assign win  = pwin | cwin;

  // overlong row closes at the last buffer column
  assign rend    = a_pix_q.row_end || a_pix_q.frame_end || (col_q == LAST_COL);
  assign has_mid = (col_q != '0);
  assign num     = {1'b0, has_mid} + {1'b0, rend};

  // delayed pixel sees x-2..x+1, the row end pixel has no right neighbor
  always_comb begin
    res_mid.light_mask    = enemy_blue_q ? (pend_q.color && (|win)) : pend_q.color;
    res_mid.bright_mask   = pend_q.bright;
    res_mid.out_row_end   = 1'b0;
    res_mid.out_frame_end = 1'b0;
    res_end.light_mask    = enemy_blue_q ? (color && (|win[WIN_W-2:0])) : color;
    res_end.bright_mask   = bright;
    res_end.out_row_end   = 1'b1;
    res_end.out_frame_end = a_pix_q.frame_end;
  end

  assign free  = RES_CNT_W'(RES_DEPTH) - fifo_count;
  assign a_adv = a_valid_q && (free >= RES_CNT_W'(num));

  always_comb begin
    push.num    = a_adv ? num : 2'd0;
    push.first  = has_mid ? res_mid : res_end;
    push.second = res_end;
  end

  assign next_col = rend ? '0 : col_q + COL_W'(1);
  assign col_ext  = FILL_W'(col_q);

  always_comb begin
    col_d       = col_q;
    fill_d      = fill_q;
    cur_win_d   = cur_win_q;
    prev_win_d  = prev_win_q;
    pend_d      = pend_q;
    first_row_d = first_row_q;
    if (a_adv) begin
      col_d = next_col;
      // written columns always run from zero upward
      if (col_ext >= fill_q) begin
        fill_d = col_ext + FILL_W'(1);
      end
      if (rend) begin
        cur_win_d   = '0;
        prev_win_d  = '0;
        pend_d      = '0;
        first_row_d = a_pix_q.frame_end;
      end else begin
        cur_win_d   = cwin[WIN_W-2:0];
        prev_win_d  = pwin[WIN_W-2:0];
        pend_d      = '{bright: bright, color: color};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      fill_q       <= '0;
      cur_win_q    <= '0;
      prev_win_q   <= '0;
      pend_q       <= '0;
      first_row_q  <= 1'b1;
      lb_ok_q      <= 1'b0;
      lb_fwd_q     <= 1'b0;
      lb_fwd_bit_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      fill_q      <= fill_d;
      cur_win_q   <= cur_win_d;
      prev_win_q  <= prev_win_d;
      pend_q      <= pend_d;
      first_row_q <= first_row_d;
      if (a_adv) begin
        // a one-pixel row reads back the column it writes
        lb_ok_q      <= FILL_W'(next_col) < fill_d;
        lb_fwd_q     <= (next_col == col_q);
        lb_fwd_bit_q <= bright;
      end
    end
  end

  // write this column, fetch the next one for the following pixel
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      lb_mem[col_q] <= bright;
      lb_rd_q       <= lb_mem[next_col];
    end
  end

  // ---------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------
  lbpm_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .count_o     (fifo_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  `LBPM_ASSERT_NOW(a_queue_bound, fifo_count <= RES_CNT_W'(RES_DEPTH), "result queue overflow")
  `LBPM_ASSERT_NEXT(a_row_wrap, a_adv && rend, !(|{col_q, pend_q}), "row state not cleared")
  `LBPM_ASSERT_NEXT(a_frame_first, a_adv && a_pix_q.frame_end, first_row_q, "no new frame")
  `LBPM_ASSERT_NEXT(a_fill_mono, 1'b1, fill_q >= $past(fill_q), "line buffer fill count went down")

endmodule

// ----- tb/light_bar_pixel_mask_tb.sv -----
`timescale 1ns / 1ps

module light_bar_pixel_mask_tb
  import lbpm_pkg::*;
();

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int COL_W = $clog2(MAX_W);
  // cycle budget, many times the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 600000;
  // random items per phase, phases alternate the idling pattern
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  pix_t        in_pix_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  res_t        out_res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  light_bar_pixel_mask uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_pix_i   (in_pix_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pixels waiting to be driven and mask results waiting to come out
  pix_t pix_queue[$];
  res_t mask_expect[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  bit          pix_taken = 1'b0;

  // register copies held by the predictor
  logic       cfg_blue_rule = 1'b0;
  logic [7:0] cfg_gray_thr = '0;
  logic [7:0] cfg_red_thr = '0;
  logic [7:0] cfg_blue_thr = '0;

  // predictor state: line buffer of bright bits, 4-column windows,
  // the delayed pixel's color/bright bits, column and first-row flag
  bit          line_bright[MAX_W];
  bit   [3:0]  cur_win = '0;
  bit   [3:0]  above_win = '0;
  bit          pend_color = 1'b0;
  bit          pend_bright = 1'b0;
  int unsigned line_col = 0;
  bit          first_line = 1'b1;

  // rule for light bit is applied when the result is predicted, at pixel acceptance
  function automatic res_t mask_result(input logic color, input logic bright,
                                       input logic dil, input logic rend,
                                       input logic fend);
    res_t r;
    r.light_mask    = cfg_blue_rule ? (color & dil) : color;
    r.bright_mask   = bright;
    r.out_row_end   = rend;
    r.out_frame_end = fend;
    return r;
  endfunction

  task automatic predict_pixel(input pix_t p);
    int unsigned col_now;
    int unsigned gray_lvl;
    logic        eol;
    logic        bright;
    logic        color;
    logic        above;
    logic [7:0]  diff;
    logic [7:0]  thr;
    col_now = (line_col >= MAX_W) ? MAX_W - 1 : line_col;
    // an overlong row is cut at the last line buffer column
    eol = p.row_end | p.frame_end | (col_now == MAX_W - 1);
    gray_lvl = (1868 * int'(p.blue) + 9617 * int'(p.green) + 4899 * int'(p.red)
                + 8192) >> 14;
    bright = gray_lvl > cfg_gray_thr;
    if (cfg_blue_rule) begin
      diff = (p.blue > p.red) ? p.blue - p.red : 8'd0;
      thr  = cfg_blue_thr;
    end else begin
      diff = (p.red > p.blue) ? p.red - p.blue : 8'd0;
      thr  = cfg_red_thr;
    end
    color = diff > thr;
    above = first_line ? 1'b0 : line_bright[COL_W'(col_now)];
    above_win = {above_win[2:0], above};
    cur_win   = {cur_win[2:0], bright};
    line_bright[COL_W'(col_now)] = bright;
    // delayed pixel sees columns x-2..x+1
    if (col_now > 0)
      mask_expect.push_back(mask_result(pend_color, pend_bright,
                                        |(cur_win | above_win), 1'b0, 1'b0));
    if (eol) begin
      // row end pixel has no right neighbor
      mask_expect.push_back(mask_result(color, bright,
                                        |((cur_win | above_win) & 4'b0111),
                                        1'b1, p.frame_end));
      line_col    = 0;
      cur_win     = '0;
      above_win   = '0;
      pend_color  = 1'b0;
      pend_bright = 1'b0;
      first_line  = p.frame_end;
    end else begin
      pend_color  = color;
      pend_bright = bright;
      line_col    = col_now + 1;
    end
  endtask

  task automatic report_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // sampling side: pixel acceptance feeds the predictor, results are checked
  always @(posedge clk_i) begin
    res_t want;
    pix_taken = rst_ni && in_valid_i && in_ready_o;
    if (pix_taken)
      predict_pixel(in_pix_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mask_expect.size() == 0) begin
        $display("%0t: result with none expected, got %b", $time, out_res_o);
        err_cnt++;
      end else begin
        want = mask_expect.pop_front();
        report_field("light_mask", want.light_mask, out_res_o.light_mask);
        report_field("bright_mask", want.bright_mask, out_res_o.bright_mask);
        report_field("out_row_end", want.out_row_end, out_res_o.out_row_end);
        report_field("out_frame_end", want.out_frame_end, out_res_o.out_frame_end);
      end
    end
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // pixel driver and result backpressure, both change at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || pix_taken) begin
        if (pix_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_pix_i   <= pix_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // register write followed by a read back of the same register
  task automatic cfg_access(input reg_idx_e idx, input logic [7:0] val);
    logic [31:0] want;
    want = 32'(val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= want;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %s read back, expected %h, got %h",
               $time, idx.name(), want, prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ENEMY_IS_BLUE:  cfg_blue_rule = val[0];
      REG_GRAY_THRESHOLD: cfg_gray_thr = val;
      REG_RED_THRESHOLD:  cfg_red_thr = val;
      REG_BLUE_THRESHOLD: cfg_blue_thr = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic blue_rule, input logic [7:0] gray_thr,
                            input logic [7:0] red_thr, input logic [7:0] blue_thr);
    cfg_access(REG_ENEMY_IS_BLUE, {7'd0, blue_rule});
    cfg_access(REG_GRAY_THRESHOLD, gray_thr);
    cfg_access(REG_RED_THRESHOLD, red_thr);
    cfg_access(REG_BLUE_THRESHOLD, blue_thr);
  endtask

  // wait until every pixel went in and every result came out, then let a
  // held row start pixel settle inside the block
  task automatic drain(input int settle);
    do
      @(negedge clk_i);
    while (pix_queue.size() != 0 || in_valid_i || mask_expect.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  function automatic pix_t px(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic re, input logic fe);
    pix_t p;
    p.blue      = b;
    p.green     = g;
    p.red       = r;
    p.row_end   = re;
    p.frame_end = fe;
    return p;
  endfunction

  // mix of dark, white, bluish, reddish and plain random pixels
  function automatic pix_t rand_pixel();
    pix_t p;
    p = px(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
           1'b0, 1'b0);
    case ($urandom_range(5))
      0: begin
        p.blue  = 8'($urandom_range(31));
        p.green = 8'($urandom_range(31));
        p.red   = 8'($urandom_range(31));
      end
      1: begin
        p.blue  = 8'($urandom_range(200, 255));
        p.green = 8'($urandom_range(200, 255));
        p.red   = 8'($urandom_range(200, 255));
      end
      2: begin
        p.blue = 8'($urandom_range(64, 255));
        p.red  = 8'($urandom_range(p.blue));
      end
      3: begin
        p.red  = 8'($urandom_range(64, 255));
        p.blue = 8'($urandom_range(p.red));
      end
      default: ;
    endcase
    return p;
  endfunction

  // well-formed frame: a few rows of mostly short, uneven widths
  task automatic push_frame();
    int   rows;
    int   w;
    pix_t p;
    rows = $urandom_range(1, 4);
    for (int y = 0; y < rows; y++) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      for (int x = 0; x < w; x++) begin
        p = rand_pixel();
        p.row_end   = (x == w - 1) && (y < rows - 1 || $urandom_range(1));
        p.frame_end = (x == w - 1) && (y == rows - 1);
        pix_queue.push_back(p);
      end
    end
  endtask

  // random row and frame markers, closed by a row end
  task automatic push_noise();
    int   n;
    pix_t p;
    n = $urandom_range(6, 12);
    for (int i = 0; i < n; i++) begin
      p = rand_pixel();
      p.row_end   = ($urandom_range(3) == 0) || (i == n - 1);
      p.frame_end = $urandom_range(7) == 0;
      pix_queue.push_back(p);
    end
  endtask

  initial begin
    int   target;
    int   idle_mode;
    pix_t p;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // red rule, zero gray and red thresholds: channel extremes, one-pixel rows,
    // a three-pixel row and a frame end without a row end
    set_config(1'b0, 8'd0, 8'd0, 8'd255);
    pix_queue.push_back(px(8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
    pix_queue.push_back(px(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    pix_queue.push_back(px(8'd0, 8'd0, 8'd255, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd128, 8'd64, 8'd200, 1'b1, 1'b0));
    pix_queue.push_back(px(8'd0, 8'd255, 8'd0, 1'b0, 1'b1));
    drain(8);

    // blue rule with dilation: a white pixel next to blue ones in the first
    // row, the row below sees it through the line buffer, then a new frame
    set_config(1'b1, 8'd100, 8'd255, 8'd0);
    pix_queue.push_back(px(8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd255, 8'd0, 8'd0, 1'b1, 1'b0));
    pix_queue.push_back(px(8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    pix_queue.push_back(px(8'd255, 8'd0, 8'd0, 1'b0, 1'b1));
    pix_queue.push_back(px(8'd255, 8'd0, 8'd0, 1'b1, 1'b1));
    // row start held across a rule change
    pix_queue.push_back(px(8'd255, 8'd255, 8'd0, 1'b0, 1'b0));
    drain(8);

    for (int k = 0; k < NUM_PHASES; k++) begin
      case (k)
        0: set_config(1'b0, 8'd0, 8'd0, 8'd0);
        1: set_config(1'b1, 8'd0, 8'd255, 8'd0);
        2: set_config(1'b0, 8'd255, 8'd255, 8'd255);
        3: set_config(1'b1, 8'd255, 8'd0, 8'd0);
        default: set_config(k[0],
                            8'(($urandom_range(9) < 7) ? $urandom_range(10, 120)
                                                       : $urandom_range(255)),
                            8'($urandom_range(150)), 8'($urandom_range(150)));
      endcase
      idle_mode = k % 4;
      send_idle_pct  = (idle_mode == 1) ? 87 : (idle_mode == 3) ? 29 : 0;
      recv_stall_pct = (idle_mode == 2) ? 87 : (idle_mode == 3) ? 29 : 0;

      if (k == 0) begin
        // close the held row
        p = rand_pixel();
        p.row_end = 1'b1;
        pix_queue.push_back(p);
      end
      target = pix_queue.size() + PHASE_ITEMS;
      while (pix_queue.size() < target) begin
        if ($urandom_range(9) == 0)
          push_noise();
        else
          push_frame();
      end
      // sometimes leave a row open into the next setting
      if ($urandom_range(2) == 0) begin
        repeat ($urandom_range(1, 4)) pix_queue.push_back(rand_pixel());
      end
      drain(8);
    end

    drain(20);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
